>>> rtl/core/assert_macros.svh
// assertion macros shared by the register file modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/core/viorf_pkg.sv
// types and constants of the register file block
// no dependencies
package viorf_pkg;
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_LOAD  = 2'd3;

    localparam logic [3:0] REG_ORB  = 4'h0;
    localparam logic [3:0] REG_ORA  = 4'h1;
    localparam logic [3:0] REG_DDRB = 4'h2;
    localparam logic [3:0] REG_DDRA = 4'h3;
    localparam logic [3:0] REG_T1CL = 4'h4;
    localparam logic [3:0] REG_T1CH = 4'h5;
    localparam logic [3:0] REG_T1LL = 4'h6;
    localparam logic [3:0] REG_T1LH = 4'h7;
    localparam logic [3:0] REG_T2L  = 4'h8;
    localparam logic [3:0] REG_T2H  = 4'h9;
    localparam logic [3:0] REG_SR   = 4'hA;
    localparam logic [3:0] REG_ACR  = 4'hB;
    localparam logic [3:0] REG_PCR  = 4'hC;
    localparam logic [3:0] REG_IFR  = 4'hD;
    localparam logic [3:0] REG_IER  = 4'hE;
    localparam logic [3:0] REG_ORAN = 4'hF;

    localparam int VALUE_DEPTH = 24;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] address;
        logic [7:0] write_data;
        logic [6:0] tick_cycles;
        logic [4:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_pending;
        logic [15:0] output_word;
        logic        set_request;
        logic [2:0]  set_index;
        logic [5:0]  set_value;
        logic        strobe_visible;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;    // apply item (read/write/load, tick start)
        logic wrap;     // one slot wrap step
        logic finish;   // tick tail: strobe and timer
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_wrap;
    } t_dp_sts;
endpackage

>>> rtl/core/viorf_if.sv
// valid/ready channel interface carrying one payload
// depends on nothing
interface viorf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/viorf_ctrl.sv
// controller: sequences item start, slot wraps, tick finish, output
// depends on viorf_pkg and assert_macros.svh
`include "assert_macros.svh"
module viorf_ctrl import viorf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_is_tick,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_load_out,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);
    typedef enum logic [1:0] {S_IDLE, S_WRAP, S_DONE} t_state;
    t_state r_state;
    logic   r_out_valid;
    logic   acc;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd.start  = acc;
        o_cmd.wrap   = (r_state == S_WRAP) && i_sts.need_wrap;
        o_cmd.finish = (r_state == S_WRAP) && !i_sts.need_wrap;
        o_load_out   = (acc && !i_in_is_tick) || (r_state == S_DONE);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc && i_in_is_tick) r_state <= S_WRAP;
                S_WRAP: if (!i_sts.need_wrap) r_state <= S_DONE;
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, r_out_valid)
    `ASSERT_IMPLIES(a_cmd_excl, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd))
endmodule

>>> rtl/core/viorf_dp.sv
// datapath: register file, timer 1, broadcast slot and result register
// depends on viorf_pkg and assert_macros.svh
`include "assert_macros.svh"
module viorf_dp import viorf_pkg::*; #(
    parameter int NUM_SLOTS     = 24,
    parameter int SLOT_PERIOD   = 100,
    parameter int STROBE_CYCLES = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    input  logic      i_load_out,
    output t_dp_sts   o_sts,
    output t_out_item o_out
);
    localparam int PH_W = 8;
    localparam logic [PH_W-1:0] PERIOD = PH_W'(SLOT_PERIOD);
    localparam logic [PH_W-1:0] STROBE = PH_W'(STROBE_CYCLES);
    localparam logic [4:0] LAST_SLOT = 5'(NUM_SLOTS - 1);

    logic [7:0] r_orb, r_ora, r_ddrb, r_ddra, r_t1ll, r_t1lh, r_t2l, r_t2h;
    logic [7:0] r_sr, r_acr, r_pcr, r_hi_held;
    logic [6:0] r_ifr, r_ier;
    logic [15:0] r_t1, r_latched;
    logic r_t1_run, r_strobe_on, r_strobe_used, r_hi_seen, r_rw_mode;
    logic [4:0] r_slot;
    logic [PH_W-1:0] r_phase;
    logic [6:0] r_cyc;
    logic [7:0] r_vals [VALUE_DEPTH];
    logic [VALUE_DEPTH-1:0] r_vals_ok;
    logic [7:0] r_rd;
    logic r_req;
    logic [2:0] r_sidx;
    logic [5:0] r_sval;

    logic [7:0] pa_view, pb_in, rd;
    logic       strobe_vis;
    logic       shift_mode;
    logic       req_ok, req_fire, set_fire;
    logic [15:0] t1_reload;

    assign o_sts.need_wrap = (r_phase >= PERIOD);
    assign strobe_vis = r_strobe_on && !r_strobe_used;
    assign pa_view = (r_ora & r_ddra) | ({strobe_vis, 2'b00, r_slot} & ~r_ddra);
    assign shift_mode = (r_acr[4:2] == 3'b110);
    assign t1_reload = {r_t1lh, r_t1ll};
    assign req_ok = i_item.write_data[6] && !r_rw_mode && (r_ddrb == 8'hFF)
                    && (r_ddra == 8'hFF);
    assign req_fire = req_ok && (r_orb <= 8'd5)
                      && ((r_orb != 8'd0) || (i_item.write_data[5:0] != 6'd0));
    assign set_fire = (i_item.kind == KIND_WRITE) && (i_item.address == REG_ORA)
                      && req_fire;

    // port B input from the slot value store
    always_comb begin
        pb_in = 8'h00;
        if (r_slot < 5'(VALUE_DEPTH) && r_vals_ok[r_slot]) pb_in = r_vals[r_slot];
    end

    // read mux
    always_comb begin
        unique case (i_item.address)
            REG_ORB:  rd = (r_orb & r_ddrb) | (pb_in & ~r_ddrb);
            REG_ORA:  rd = pa_view;
            REG_DDRB: rd = r_ddrb;
            REG_DDRA: rd = r_ddra;
            REG_T1CL: rd = r_t1[7:0];
            REG_T1CH: rd = r_t1[15:8];
            REG_T1LL: rd = r_t1ll;
            REG_T1LH: rd = r_t1lh;
            REG_T2L:  rd = r_t2l;
            REG_T2H:  rd = r_t2h;
            REG_SR:   rd = r_sr;
            REG_ACR:  rd = r_acr;
            REG_PCR:  rd = r_pcr;
            REG_IFR:  rd = {|(r_ifr & r_ier), r_ifr};
            REG_IER:  rd = {1'b1, r_ier};
            default:  rd = pa_view;
        endcase
    end

    // slot values: valid bits cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vals_ok <= '0;
        end else if (i_cmd.start && i_item.kind == KIND_LOAD
                     && i_item.slot_index < 5'(VALUE_DEPTH)) begin
            r_vals_ok[i_item.slot_index] <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_item.kind == KIND_LOAD
            && i_item.slot_index < 5'(VALUE_DEPTH)) begin
            r_vals[i_item.slot_index] <= i_item.write_data;
        end
    end

    // register file, timer and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orb <= '0; r_ora <= '0; r_ddrb <= '0; r_ddra <= '0;
            r_t1ll <= '0; r_t1lh <= '0; r_t2l <= '0; r_t2h <= '0;
            r_sr <= '0; r_acr <= '0; r_pcr <= '0; r_hi_held <= '0;
            r_ifr <= '0; r_ier <= '0; r_t1 <= '0; r_latched <= '0;
            r_t1_run <= 1'b0; r_strobe_on <= 1'b0; r_strobe_used <= 1'b0;
            r_hi_seen <= 1'b0; r_rw_mode <= 1'b0; r_slot <= '0; r_phase <= '0;
            r_cyc <= '0; r_rd <= '0; r_req <= 1'b0; r_sidx <= '0; r_sval <= '0;
        end else begin
            if (i_cmd.start) begin
                // result fields of this item
                r_rd   <= (i_item.kind == KIND_READ) ? rd : 8'h00;
                r_req  <= set_fire;
                r_sidx <= set_fire ? r_orb[2:0] : 3'd0;
                r_sval <= set_fire ? i_item.write_data[5:0] : 6'd0;
                unique case (i_item.kind)
                    KIND_READ: begin
                        if (i_item.address == REG_ORA) r_strobe_used <= 1'b1;
                        if (i_item.address == REG_T1CL) r_ifr[6] <= 1'b0;
                        if (i_item.address == REG_T2L) r_ifr[5] <= 1'b0;
                    end
                    KIND_WRITE: begin
                        unique case (i_item.address)
                            REG_ORB: r_orb <= i_item.write_data;
                            REG_ORA: begin
                                r_ora <= i_item.write_data;
                                if (!i_item.write_data[6]) r_rw_mode <= 1'b0;
                                else if (req_ok) r_rw_mode <= 1'b1;
                            end
                            REG_DDRB: r_ddrb <= i_item.write_data;
                            REG_DDRA: r_ddra <= i_item.write_data;
                            REG_T1CL, REG_T1LL: r_t1ll <= i_item.write_data;
                            REG_T1CH: begin
                                r_t1lh <= i_item.write_data;
                                r_t1 <= {i_item.write_data, r_t1ll};
                                r_t1_run <= 1'b1;
                                r_ifr[6] <= 1'b0;
                            end
                            REG_T1LH: begin
                                r_t1lh <= i_item.write_data;
                                r_ifr[6] <= 1'b0;
                            end
                            REG_T2L: r_t2l <= i_item.write_data;
                            REG_T2H: begin
                                r_t2h <= i_item.write_data;
                                r_ifr[5] <= 1'b0;
                            end
                            REG_SR: begin
                                r_sr <= i_item.write_data;
                                if (shift_mode) begin
                                    if (!r_hi_seen) begin
                                        r_hi_held <= i_item.write_data;
                                        r_hi_seen <= 1'b1;
                                    end else begin
                                        r_latched <= {r_hi_held, i_item.write_data};
                                        r_hi_seen <= 1'b0;
                                    end
                                end
                            end
                            REG_ACR: begin
                                r_acr <= i_item.write_data;
                                if (i_item.write_data[4:2] != 3'b110) r_hi_seen <= 1'b0;
                            end
                            REG_PCR: r_pcr <= i_item.write_data;
                            REG_IFR: r_ifr <= r_ifr & ~i_item.write_data[6:0];
                            REG_IER: begin
                                if (i_item.write_data[7])
                                    r_ier <= r_ier | i_item.write_data[6:0];
                                else
                                    r_ier <= r_ier & ~i_item.write_data[6:0];
                            end
                            default: r_ora <= i_item.write_data;
                        endcase
                    end
                    KIND_TICK: begin
                        r_cyc <= i_item.tick_cycles;
                        r_phase <= r_phase + PH_W'(i_item.tick_cycles);
                    end
                    default: ;
                endcase
            end
            // one slot wrap per cycle
            if (i_cmd.wrap) begin
                r_phase <= r_phase - PERIOD;
                r_slot <= (r_slot == LAST_SLOT) ? 5'd0 : r_slot + 5'd1;
                r_strobe_used <= 1'b0;
            end
            // strobe and timer 1 once the phase is settled, for a nonzero tick
            if (i_cmd.finish && r_cyc != 7'd0) begin
                r_strobe_on <= (r_phase < STROBE);
                if (r_t1_run) begin
                    if (r_t1 <= 16'(r_cyc)) begin
                        r_ifr[6] <= 1'b1;
                        if (r_acr[6]) r_t1 <= t1_reload;
                        else begin
                            r_t1_run <= 1'b0;
                            r_t1 <= 16'd0;
                        end
                    end else begin
                        r_t1 <= r_t1 - 16'(r_cyc);
                    end
                end
            end
        end
    end

    // result item
    always_comb begin
        o_out.read_data      = r_rd;
        o_out.irq_pending    = |(r_ifr & r_ier);
        o_out.output_word    = r_latched;
        o_out.set_request    = r_req;
        o_out.set_index      = r_sidx;
        o_out.set_value      = r_sval;
        o_out.strobe_visible = r_strobe_on && !r_strobe_used;
    end

    // i_load_out marks when the result registers are final
    `ASSERT_IMPLIES(a_load_no_wrap, i_clk, i_rst_n, i_load_out && !i_cmd.start,
                    !o_sts.need_wrap)
    `ASSERT_IMPLIES(a_slot_range, i_clk, i_rst_n, 1'b1, r_slot <= LAST_SLOT)
    `ASSERT_NEXT(a_req_index, i_clk, i_rst_n, i_cmd.start, r_sidx <= 3'd5)
endmodule

>>> rtl/core/via_io_board_register_file_core.sv
// top level of the register file block
// depends on viorf_pkg, viorf_if, viorf_ctrl, viorf_dp
// Each item yields one result. Bus reads, writes and slot loads go into the
// result register when taken; a tick adds to the phase, wraps slots W times
// (one subtract per cycle in the phase loop, at most 2 for the default
// period), finishes, then raises the result. A new item is taken only when
// idle, with no result waiting or the waiting result transferred in the
// same cycle. Slot values read as zero until loaded (valid bit per entry).
module via_io_board_register_file_core import viorf_pkg::*; #(
    parameter int NUM_SLOTS     = 24,
    parameter int SLOT_PERIOD   = 100,
    parameter int STROBE_CYCLES = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    viorf_if.sink   i_in,
    viorf_if.source o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    load_out;
    t_in_item item;

    assign item = i_in.data;

    viorf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_in_is_tick(item.kind == KIND_TICK),
        .o_in_ready(i_in.ready), .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid), .o_load_out(load_out),
        .o_cmd(cmd), .i_sts(sts)
    );

    viorf_dp #(
        .NUM_SLOTS(NUM_SLOTS), .SLOT_PERIOD(SLOT_PERIOD),
        .STROBE_CYCLES(STROBE_CYCLES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_cmd(cmd),
        .i_load_out(load_out), .o_sts(sts), .o_out(o_out.data)
    );
endmodule
